// ----- rtl/dbpc_pkg.sv -----
package dbpc_pkg;

    localparam int PAGE_BYTES = 256;
    localparam int PAGE_LOG2  = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 13;
    localparam int PASS_W     = 24;

    localparam logic [LEN_W-1:0]  PAGE_LEN       = LEN_W'(PAGE_BYTES);
    localparam logic [PASS_W-1:0] PASS_MAX       = {PASS_W{1'b1}};
    localparam logic [PASS_W-1:0] WATCHDOG_RESET = 24'hFFF000;

    localparam logic [1:0] REG_WIN_LOW  = 2'd0;
    localparam logic [1:0] REG_WIN_HIGH = 2'd1;
    localparam logic [1:0] REG_WD_LIMIT = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_PASS  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DMA     = 3'd1,
        PH_WRITING = 3'd2,
        PH_READY   = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] src_start;
        logic [ADDR_W-1:0] dst_start;
        logic [ADDR_W-1:0] total_len;
        logic              dma_done;
        logic              poll_tick;
        logic              wip_busy;
        logic              spi2_free;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              buffer;
        logic [2:0]        state_now;
        logic              rejected;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] win_low;
        logic [ADDR_W-1:0] win_high;
        logic [PASS_W-1:0] wd_limit;
    } cfg_t;

    typedef struct packed {
        phase_t                  phase;
        logic                    active_buffer;
        logic [1:0][LEN_W-1:0]   buf_len;
        logic [ADDR_W-1:0]       src_ptr;
        logic [ADDR_W-1:0]       dst_ptr;
        logic [ADDR_W-1:0]       bytes_left;
        logic [PASS_W-1:0]       pass_count;
        logic                    busy_cleared;
        logic                    next_filled;
    } seq_state_t;

    typedef struct packed {
        out_item_t first;
        out_item_t second;
        logic      two;
    } step_out_t;

endpackage

// ----- rtl/dbpc_step.sv -----
module dbpc_step
    import dbpc_pkg::*;
(
    input  seq_state_t cur,
    input  in_item_t   item,
    input  cfg_t       cfg,
    output seq_state_t nxt,
    output step_out_t  res
);

    logic [PAGE_LOG2-1:0] offset;
    logic [LEN_W-1:0]     space;
    logic [LEN_W-1:0]     chunk;
    logic [LEN_W-1:0]     rd_size;
    logic [LEN_W-1:0]     wr_size;
    logic                 refused;
    logic                 running;
    logic                 rd_go;
    logic                 wr_go;
    logic                 nb;
    out_item_t            rd_cmd;
    out_item_t            wr_cmd;
    out_item_t            status;

    always_comb begin
        nxt     = cur;
        offset  = item.dst_start[PAGE_LOG2-1:0];
        space   = PAGE_LEN - LEN_W'(offset);
        chunk   = (item.total_len > ADDR_W'(space)) ? space : item.total_len[LEN_W-1:0];
        rd_size = (cur.bytes_left >= ADDR_W'(PAGE_LEN)) ? PAGE_LEN
                                                         : cur.bytes_left[LEN_W-1:0];
        wr_size = '0;
        refused = 1'b0;
        rd_go   = 1'b0;
        wr_go   = 1'b0;
        nb      = ~cur.active_buffer;
        running = (cur.phase == PH_DMA) || (cur.phase == PH_WRITING) ||
                  (cur.phase == PH_READY);
        rd_cmd  = '0;
        wr_cmd  = '0;

        if (item.operation == OP_START) begin
            if ((item.total_len == '0) || (item.src_start < cfg.win_low) ||
                (item.src_start > cfg.win_high)) begin
                refused = 1'b1;
            end else begin
                // first read is cut short so later writes land page aligned
                rd_go             = 1'b1;
                wr_go             = 1'b1;
                rd_cmd.kind       = KIND_READ;
                rd_cmd.address    = item.src_start;
                rd_cmd.length     = chunk;
                wr_cmd.kind       = KIND_WRITE;
                wr_cmd.address    = item.dst_start;
                wr_cmd.length     = chunk;
                nxt.phase         = PH_DMA;
                nxt.active_buffer = 1'b0;
                nxt.buf_len       = '0;
                nxt.src_ptr       = item.src_start + ADDR_W'(chunk);
                nxt.dst_ptr       = item.dst_start + ADDR_W'(chunk);
                nxt.bytes_left    = item.total_len - ADDR_W'(chunk);
                nxt.pass_count    = '0;
                nxt.busy_cleared  = 1'b0;
                nxt.next_filled   = 1'b0;
            end
        end else if (running) begin
            if ((nxt.phase == PH_DMA) && item.dma_done) begin
                nxt.phase = (cur.bytes_left == '0) ? PH_DONE : PH_WRITING;
            end
            if ((nxt.phase == PH_WRITING) && item.poll_tick && !item.wip_busy) begin
                nxt.busy_cleared = 1'b1;
                if (cur.next_filled) begin
                    nxt.phase = PH_READY;
                end
            end
            // prefill the standby buffer
            if ((nxt.phase == PH_WRITING) && item.spi2_free && nxt.busy_cleared &&
                !cur.next_filled && (cur.bytes_left != '0)) begin
                rd_go           = 1'b1;
                rd_cmd.kind     = KIND_READ;
                rd_cmd.address  = cur.src_ptr;
                rd_cmd.length   = rd_size;
                rd_cmd.buffer   = nb;
                nxt.src_ptr     = cur.src_ptr + ADDR_W'(rd_size);
                nxt.buf_len[nb] = rd_size;
                nxt.next_filled = 1'b1;
                nxt.phase       = PH_READY;
            end
            if (nxt.phase == PH_READY) begin
                nxt.active_buffer = nb;
                wr_size           = nxt.buf_len[nb];
                if ((wr_size == '0) || (wr_size > PAGE_LEN)) begin
                    nxt.phase = PH_ERROR;
                end else begin
                    wr_go            = 1'b1;
                    wr_cmd.kind      = KIND_WRITE;
                    wr_cmd.address   = cur.dst_ptr;
                    wr_cmd.length    = wr_size;
                    wr_cmd.buffer    = nb;
                    nxt.phase        = PH_DMA;
                    nxt.busy_cleared = 1'b0;
                    nxt.next_filled  = 1'b0;
                    nxt.buf_len[nb]  = '0;
                    nxt.dst_ptr      = cur.dst_ptr + ADDR_W'(wr_size);
                    nxt.bytes_left   = cur.bytes_left - ADDR_W'(wr_size);
                end
            end
            // watchdog
            if (cur.pass_count != PASS_MAX) begin
                nxt.pass_count = cur.pass_count + PASS_W'(1);
            end
            if (nxt.pass_count > cfg.wd_limit) begin
                nxt.phase = PH_ERROR;
            end
        end

        status          = '0;
        status.kind     = KIND_STATUS;
        status.rejected = refused;

        res.two    = rd_go && wr_go;
        res.first  = rd_go ? rd_cmd : (wr_go ? wr_cmd : status);
        res.second = wr_cmd;
        res.first.state_now  = nxt.phase;
        res.second.state_now = nxt.phase;
        res.first.last       = !res.two;
        res.second.last      = 1'b1;
    end

endmodule

// ----- rtl/dbpc_out_queue.sv -----
module dbpc_out_queue
    import dbpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  step_out_t push_data,
    output logic      room,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    out_item_t   mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;
    logic [2:0]  push_n;

    assign m_valid = (count_reg != 3'd0);
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    // room for a two-result transaction
    assign room    = (count_reg <= 3'd2);
    assign push_n  = push ? (push_data.two ? 3'd2 : 3'd1) : 3'd0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + push_n - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data.first;
            if (push_data.two) begin
                mem[wr_ptr_reg + 2'd1] <= push_data.second;
            end
        end
    end

endmodule

// ----- rtl/double_buffer_page_copy_sequencer.sv -----
// channel   ports                          payload
// input     s_valid / s_ready / s_data     in_item_t  (start or control pass)
// result    m_valid / m_ready / m_data     out_item_t (status, read or write)
// config    cfg_wr_en / cfg_index / cfg_wdata
//
// a registered transaction is stepped combinationally into a 4-entry result queue
// one input transaction per cycle while the queue has room
// a transaction with two commands pushes both results into the queue together
// the step waits only while the queue has fewer than two free entries
// aresetn is synchronous: phase idle, all pointers and counters cleared
module double_buffer_page_copy_sequencer
    import dbpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [ADDR_W-1:0] cfg_wdata
);

    logic              in_valid_reg;
    in_item_t          in_data_reg;
    seq_state_t        state_reg;
    seq_state_t        state_next;
    cfg_t              cfg_reg;
    step_out_t         step_res;
    logic              room;
    logic              fire;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.win_low  <= '0;
            cfg_reg.win_high <= '1;
            cfg_reg.wd_limit <= WATCHDOG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WIN_LOW:  cfg_reg.win_low  <= cfg_wdata;
                REG_WIN_HIGH: cfg_reg.win_high <= cfg_wdata;
                REG_WD_LIMIT: cfg_reg.wd_limit <= cfg_wdata[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    // all-zero state is phase idle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    dbpc_step u_step (
        .cur  (state_reg),
        .item (in_data_reg),
        .cfg  (cfg_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    dbpc_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire),
        .push_data (step_res),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    a_start_goes_dma: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_data_reg.operation == OP_START) && !step_res.first.rejected
        |=> (state_reg.phase == PH_DMA) && (state_reg.pass_count == '0))
        else $error("accepted start did not enter dma active");

    a_idle_pass_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (in_data_reg.operation == OP_PASS) &&
        ((state_reg.phase == PH_IDLE) || (state_reg.phase == PH_DONE) ||
         (state_reg.phase == PH_ERROR))
        |=> $stable(state_reg))
        else $error("pass outside a transfer changed state");

    a_reject_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> (m_data.kind == KIND_STATUS) && m_data.last)
        else $error("rejected flag on a command result");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !room |=> in_valid_reg && $stable(in_data_reg))
        else $error("held transaction lost while queue full");
`endif

endmodule
